FILE: src/s256_pkg.sv
// Shared types, constants and functions for the SHA-256 stream hasher.
// Used by s256_core and sha256_stream_hasher; depends on nothing else.
`default_nettype none

package s256_pkg;

    typedef logic [31:0]       t_word;
    typedef logic [15:0][31:0] t_block;   // word 0 holds message bytes 0..3, big-endian
    typedef logic [7:0][31:0]  t_state;   // index 0 is the first hash word

    // Controls how a stored block is turned into the words that get compressed.
    typedef struct packed {
        logic use_data;   // take stored message bytes
        logic keep_all;   // all 64 stored bytes are message bytes
        logic mark;       // put the 0x80 marker at the fill position
        logic put_len;    // put the 64-bit bit length in the last eight bytes
    } t_blk_ctl;

    localparam int         BLOCK_BYTES = 64;
    localparam logic [5:0] LENGTH_POS  = 6'd56;

    localparam t_state HASH_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Round functions; rotations are fixed wiring.
    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    // Builds the block to compress: kept message bytes, the marker, zeros and
    // the bit length. Each byte position is decided on its own.
    function automatic t_block pad_block(
        input t_block     blk,
        input logic [5:0] fill,
        input t_blk_ctl   ctl,
        input logic [63:0] bit_len
    );
        t_block     res;
        logic [7:0] b;
        logic       keep;
        res = '0;
        for (int p = 0; p < BLOCK_BYTES; p++) begin
            b    = blk[p >> 2][(3 - (p & 3)) * 8 +: 8];
            keep = ctl.use_data && (ctl.keep_all || (7'(p) < {1'b0, fill}));
            if (keep) begin
                res[p >> 2][(3 - (p & 3)) * 8 +: 8] = b;
            end else if (ctl.mark && !ctl.keep_all && (7'(p) == {1'b0, fill})) begin
                res[p >> 2][(3 - (p & 3)) * 8 +: 8] = 8'h80;
            end else if (ctl.put_len && (p >= 56)) begin
                // Byte 56 takes the most significant length byte.
                res[p >> 2][(3 - (p & 3)) * 8 +: 8] = bit_len[(7 - (p & 7)) * 8 +: 8];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: src/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: byte buffer, padding, sequencer
// and digest output. Depends on s256_pkg and s256_core.
//
//  Channel  Dir  tdata               tuser           tlast
//  s_axis   in   byte_in[7:0]        has_byte        end_of_message
//  m_axis   out  digest_word[31:0]   word_index[2:0] last_word
//
// A byte that does not complete a 64-byte block keeps the input ready
// unless it ends the message. A completing byte starts a compression: the
// single round unit runs 64 rounds, one per cycle, plus load and fold-in.
// Finishing a message takes one or two such compressions, then eight
// digest transfers; the input is not ready during compression or output.
// Reset (synchronous, active low) loads the initial hash and clears counts.
// Output stalls hold the current digest word until it is taken.
`default_nettype none

module sha256_stream_hasher
    import s256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,   // end_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,   // [2:0] word_index
    output logic             m_axis_tlast    // last_word
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KICK = 3'd1;
    localparam logic [2:0] S_FULL = 3'd2;
    localparam logic [2:0] S_PAD1 = 3'd3;
    localparam logic [2:0] S_LAST = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_msg_bytes, n_msg_bytes;
    logic        r_full_pend, n_full_pend;
    logic        r_eom, n_eom;
    logic        r_pad_done, n_pad_done;
    logic [2:0]  r_widx, n_widx;
    t_state      r_chain, n_chain;
    t_block      r_block;

    logic     w_in_xfer, w_out_xfer, w_wr_byte;
    logic     w_start, w_done;
    t_blk_ctl w_ctl;
    t_block   w_pad;
    t_state   w_work;

    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_xfer = m_axis_tvalid && m_axis_tready;
    assign w_wr_byte  = w_in_xfer && s_axis_tuser;

    // Block buffer: byte writes at the fill position, big-endian in each word.
    always_ff @(posedge i_clk) begin
        if (w_wr_byte) begin
            r_block[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= s_axis_tdata;
        end
    end

    assign w_pad = pad_block(r_block, r_fill, w_ctl, {r_msg_bytes, 3'b000});

    s256_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_block (w_pad),
        .i_chain (r_chain),
        .o_done  (w_done),
        .o_work  (w_work)
    );

    // Sequencer: byte intake, block dispatch, fold-in and digest output.
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_msg_bytes = r_msg_bytes;
        n_full_pend = r_full_pend;
        n_eom       = r_eom;
        n_pad_done  = r_pad_done;
        n_widx      = r_widx;
        n_chain     = r_chain;
        w_start     = 1'b0;
        w_ctl       = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (s_axis_tuser) begin
                        n_fill      = r_fill + 6'd1;
                        n_msg_bytes = r_msg_bytes + 61'd1;
                        if (r_fill == 6'd63) begin
                            n_full_pend = 1'b1;
                            n_state     = S_KICK;
                        end
                    end
                    if (s_axis_tlast) begin
                        n_eom   = 1'b1;
                        n_state = S_KICK;
                    end
                end
            end
            S_KICK: begin
                w_start = 1'b1;
                if (r_full_pend) begin
                    w_ctl   = '{use_data: 1'b1, keep_all: 1'b1, mark: 1'b0, put_len: 1'b0};
                    n_state = S_FULL;
                end else if (r_pad_done) begin
                    // Second padding block: zeros and the length only.
                    w_ctl   = '{use_data: 1'b0, keep_all: 1'b0, mark: 1'b0, put_len: 1'b1};
                    n_state = S_LAST;
                end else if (r_fill >= LENGTH_POS) begin
                    // No room for the length: marker now, length in a second block.
                    w_ctl   = '{use_data: 1'b1, keep_all: 1'b0, mark: 1'b1, put_len: 1'b0};
                    n_state = S_PAD1;
                end else begin
                    w_ctl   = '{use_data: 1'b1, keep_all: 1'b0, mark: 1'b1, put_len: 1'b1};
                    n_state = S_LAST;
                end
            end
            S_FULL: begin
                if (w_done) begin
                    for (int i = 0; i < 8; i++) n_chain[i] = r_chain[i] + w_work[i];
                    n_full_pend = 1'b0;
                    n_state     = r_eom ? S_KICK : S_IDLE;
                end
            end
            S_PAD1: begin
                if (w_done) begin
                    for (int i = 0; i < 8; i++) n_chain[i] = r_chain[i] + w_work[i];
                    n_pad_done = 1'b1;
                    n_state    = S_KICK;
                end
            end
            S_LAST: begin
                if (w_done) begin
                    for (int i = 0; i < 8; i++) n_chain[i] = r_chain[i] + w_work[i];
                    n_widx  = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_xfer) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == 3'd7) begin
                        // Digest delivered: back to the initial state.
                        n_chain     = HASH_INIT;
                        n_fill      = '0;
                        n_msg_bytes = '0;
                        n_eom       = 1'b0;
                        n_pad_done  = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_msg_bytes <= '0;
            r_full_pend <= 1'b0;
            r_eom       <= 1'b0;
            r_pad_done  <= 1'b0;
            r_widx      <= '0;
            r_chain     <= HASH_INIT;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_msg_bytes <= n_msg_bytes;
            r_full_pend <= n_full_pend;
            r_eom       <= n_eom;
            r_pad_done  <= n_pad_done;
            r_widx      <= n_widx;
            r_chain     <= n_chain;
        end
    end

    // Port drive.
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_chain[r_widx];
    assign m_axis_tuser  = r_widx;
    assign m_axis_tlast  = (r_widx == 3'd7);

    // The input never opens while a digest is being delivered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while digest output is valid");

    // A pending full block always sits at fill position zero.
    a_full_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full_pend |-> (r_fill == 6'd0))
        else $error("full block pending with nonzero fill");

    // Compression results arrive only in a compression state.
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_FULL || r_state == S_PAD1 || r_state == S_LAST))
        else $error("compression finished outside a compression state");

    // After the last digest word the counts are cleared and input reopens.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && m_axis_tlast) |=>
            (r_fill == 6'd0 && r_msg_bytes == 61'd0 && s_axis_tready && r_chain == HASH_INIT))
        else $error("state not restored after digest");

endmodule

`default_nettype wire

FILE: src/s256_core.sv
// Iterative SHA-256 compression unit: one round per cycle for 64 rounds,
// with a 16-word sliding message schedule. Depends on s256_pkg.
`default_nettype none

module s256_core
    import s256_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,     // load block and chain, begin round 0
    input  wire t_block i_block,
    input  wire t_state i_chain,
    output logic        o_done,      // one-cycle pulse after round 63
    output t_state      o_work       // working variables a..h after the rounds
);

    logic       r_busy, n_busy;
    logic       r_done, n_done;
    logic [5:0] r_cnt,  n_cnt;
    t_state     r_work, n_work;
    t_block     r_win,  n_win;

    t_word w_t1, w_t2, w_sched;

    // One round of the compression function and one schedule step.
    always_comb begin
        w_t1 = r_work[7] + big_sigma1(r_work[4])
             + ((r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]))
             + ROUND_K[r_cnt] + r_win[0];
        w_t2 = big_sigma0(r_work[0])
             + ((r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2]) ^ (r_work[1] & r_work[2]));
        w_sched = small_sigma1(r_win[14]) + r_win[9] + small_sigma0(r_win[1]) + r_win[0];
    end

    // Sequencing of the 64 rounds.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_work = r_work;
        n_win  = r_win;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_work = i_chain;
            n_win  = i_block;
        end else if (r_busy) begin
            n_work = {r_work[6:4], r_work[3] + w_t1, r_work[2:0], w_t1 + w_t2};
            n_win  = {w_sched, r_win[15:1]};
            n_cnt  = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Working variables and schedule window carry no reset.
    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_win  <= n_win;
    end

    assign o_done = r_done;
    assign o_work = r_work;

endmodule

`default_nettype wire
